[rtl/core/tnac_pkg.sv]
`timescale 1ns / 1ps

package tnac_pkg;

  // Field and datapath widths.
  localparam int COORD_W   = 16;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int SUM_W     = COORD_W + 2;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int HALF_W    = MAG_W / 2;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int AREA_W    = ROOT_W + 1;
  localparam int NORM_W    = 16;
  localparam int NORM_FRAC = 14;
  localparam int QUO_W     = NORM_FRAC + 1;
  localparam int NQ_W      = QUO_W + 1;

  // Divider depth: the integer quotient bit plus one stage per fraction bit.
  localparam int DIV_STAGES = NORM_FRAC + 1;

  // Division by three: n * ceil(2^17 / 3) >> 17 is exact for n below 2^17.
  localparam int MID_SHIFT = 17;
  localparam logic [MID_SHIFT-1:0] MID_RECIP = MID_SHIFT'(((1 << MID_SHIFT) + 2) / 3);

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_a_x;
    logic signed [COORD_W-1:0] vertex_a_y;
    logic signed [COORD_W-1:0] vertex_a_z;
    logic signed [COORD_W-1:0] vertex_b_x;
    logic signed [COORD_W-1:0] vertex_b_y;
    logic signed [COORD_W-1:0] vertex_b_z;
    logic signed [COORD_W-1:0] vertex_c_x;
    logic signed [COORD_W-1:0] vertex_c_y;
    logic signed [COORD_W-1:0] vertex_c_z;
  } in_t;

  typedef struct packed {
    logic signed [NORM_W-1:0]  unit_normal_x;
    logic signed [NORM_W-1:0]  unit_normal_y;
    logic signed [NORM_W-1:0]  unit_normal_z;
    logic [AREA_W-1:0]         tri_area;
    logic signed [COORD_W-1:0] mid_x;
    logic signed [COORD_W-1:0] mid_y;
    logic signed [COORD_W-1:0] mid_z;
    logic                      degenerate;
  } out_t;

  // Values that ride along with the squared length through the root stages.
  typedef struct packed {
    logic [2:0]                   neg;
    logic [2:0][MAG_W-1:0]        mag;
    logic [2:0][COORD_W-1:0]      mid;
  } side_t;

  // Values that ride along with the normal divider stages.
  typedef struct packed {
    logic [ROOT_W-1:0]            len;
    logic [2:0]                   neg;
    logic [2:0][COORD_W-1:0]      mid;
  } dside_t;

endpackage

[rtl/core/tnac_front.sv]
`timescale 1ns / 1ps

module tnac_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         v_i,
  input  tnac_pkg::in_t                data_i,
  output logic                         v_o,
  output logic [tnac_pkg::SQ_W-1:0]    sq_o,
  output tnac_pkg::side_t              side_o
);

  logic signed [tnac_pkg::COORD_W-1:0] va [3];
  logic signed [tnac_pkg::COORD_W-1:0] vb [3];
  logic signed [tnac_pkg::COORD_W-1:0] vc [3];

  logic signed [tnac_pkg::EDGE_W-1:0]  e1_r [3];
  logic signed [tnac_pkg::EDGE_W-1:0]  e2_r [3];
  logic signed [tnac_pkg::SUM_W-1:0]   sum_r [3];
  logic signed [tnac_pkg::PROD_W-1:0]  p_r [6];
  logic [tnac_pkg::COORD_W-1:0]        mid2_r [3];
  logic                                v_r [1:5];
  tnac_pkg::side_t                     side3_r;
  tnac_pkg::side_t                     side4_r;
  tnac_pkg::side_t                     side5_r;
  tnac_pkg::side_t                     side6_r;
  logic [tnac_pkg::MAG_W-1:0]          pl_r [3];
  logic [tnac_pkg::MAG_W-1:0]          pm_r [3];
  logic [tnac_pkg::MAG_W-1:0]          ph_r [3];
  logic [tnac_pkg::SQ_W-1:0]           sq5_r [3];
  logic [tnac_pkg::SQ_W-1:0]           sq6_r;
  logic                                v6_r;

  assign va[0] = data_i.vertex_a_x;
  assign va[1] = data_i.vertex_a_y;
  assign va[2] = data_i.vertex_a_z;
  assign vb[0] = data_i.vertex_b_x;
  assign vb[1] = data_i.vertex_b_y;
  assign vb[2] = data_i.vertex_b_z;
  assign vc[0] = data_i.vertex_c_x;
  assign vc[1] = data_i.vertex_c_y;
  assign vc[2] = data_i.vertex_c_z;

  // Valid bits move with the data whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 5; i++) v_r[i] <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v_r[1] <= v_i;
      for (int i = 2; i <= 5; i++) v_r[i] <= v_r[i-1];
      v6_r <= v_r[5];
    end
  end

  // Stage 1: edge vectors and coordinate sums.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i]  <= tnac_pkg::EDGE_W'(vb[i]) - tnac_pkg::EDGE_W'(va[i]);
        e2_r[i]  <= tnac_pkg::EDGE_W'(vc[i]) - tnac_pkg::EDGE_W'(va[i]);
        sum_r[i] <= tnac_pkg::SUM_W'(va[i]) + tnac_pkg::SUM_W'(vb[i]) +
                    tnac_pkg::SUM_W'(vc[i]);
      end
    end
  end

  // Stage 2: the six cross products and the centroid by reciprocal multiply.
  logic [tnac_pkg::SUM_W-1:0]        smag [3];
  logic [tnac_pkg::MID_SHIFT-1:0]    nrnd [3];
  logic [2*tnac_pkg::MID_SHIFT-1:0]  mprod [3];
  logic [tnac_pkg::COORD_W-1:0]      quo3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      smag[i]  = sum_r[i][tnac_pkg::SUM_W-1] ? tnac_pkg::SUM_W'(-sum_r[i])
                                             : tnac_pkg::SUM_W'(sum_r[i]);
      nrnd[i]  = smag[i][tnac_pkg::MID_SHIFT-1:0] + tnac_pkg::MID_SHIFT'(1);
      mprod[i] = (2*tnac_pkg::MID_SHIFT)'(nrnd[i]) *
                 (2*tnac_pkg::MID_SHIFT)'(tnac_pkg::MID_RECIP);
      quo3[i]  = mprod[i][tnac_pkg::MID_SHIFT +: tnac_pkg::COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= e1_r[1] * e2_r[2];
      p_r[1] <= e1_r[2] * e2_r[1];
      p_r[2] <= e1_r[2] * e2_r[0];
      p_r[3] <= e1_r[0] * e2_r[2];
      p_r[4] <= e1_r[0] * e2_r[1];
      p_r[5] <= e1_r[1] * e2_r[0];
      for (int i = 0; i < 3; i++) begin
        mid2_r[i] <= sum_r[i][tnac_pkg::SUM_W-1] ? tnac_pkg::COORD_W'(0) - quo3[i]
                                                  : quo3[i];
      end
    end
  end

  // Stage 3: cross product components as sign and magnitude.
  logic signed [tnac_pkg::CROSS_W-1:0] xd [3];
  logic [tnac_pkg::CROSS_W-1:0]        xm [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xd[i] = tnac_pkg::CROSS_W'(p_r[2*i]) - tnac_pkg::CROSS_W'(p_r[2*i+1]);
      xm[i] = xd[i][tnac_pkg::CROSS_W-1] ? tnac_pkg::CROSS_W'(-xd[i])
                                         : tnac_pkg::CROSS_W'(xd[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        side3_r.neg[i] <= xd[i][tnac_pkg::CROSS_W-1];
        side3_r.mag[i] <= xm[i][tnac_pkg::MAG_W-1:0];
        side3_r.mid[i] <= mid2_r[i];
      end
    end
  end

  // Stage 4: partial products of each square on half-width pieces.
  logic [tnac_pkg::HALF_W-1:0] ah [3];
  logic [tnac_pkg::HALF_W-1:0] al [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ah[i] = side3_r.mag[i][tnac_pkg::MAG_W-1 -: tnac_pkg::HALF_W];
      al[i] = side3_r.mag[i][tnac_pkg::HALF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r <= side3_r;
      for (int i = 0; i < 3; i++) begin
        pl_r[i] <= tnac_pkg::MAG_W'(al[i]) * tnac_pkg::MAG_W'(al[i]);
        pm_r[i] <= tnac_pkg::MAG_W'(al[i]) * tnac_pkg::MAG_W'(ah[i]);
        ph_r[i] <= tnac_pkg::MAG_W'(ah[i]) * tnac_pkg::MAG_W'(ah[i]);
      end
    end
  end

  // Stage 5: assemble each square.
  always_ff @(posedge clk) begin
    if (en) begin
      side5_r <= side4_r;
      for (int i = 0; i < 3; i++) begin
        sq5_r[i] <= (tnac_pkg::SQ_W'(ph_r[i]) << (2*tnac_pkg::HALF_W)) +
                    (tnac_pkg::SQ_W'(pm_r[i]) << (tnac_pkg::HALF_W+1)) +
                    tnac_pkg::SQ_W'(pl_r[i]);
      end
    end
  end

  // Stage 6: squared length of the cross product.
  always_ff @(posedge clk) begin
    if (en) begin
      side6_r <= side5_r;
      sq6_r   <= sq5_r[0] + sq5_r[1] + sq5_r[2];
    end
  end

  assign v_o    = v6_r;
  assign sq_o   = sq6_r;
  assign side_o = side6_r;

endmodule

[rtl/core/tnac_sqrt.sv]
`timescale 1ns / 1ps

module tnac_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          v_i,
  input  logic [tnac_pkg::SQ_W-1:0]     rad_i,
  input  tnac_pkg::side_t               side_i,
  output logic                          v_o,
  output logic [tnac_pkg::ROOT_W-1:0]   root_o,
  output tnac_pkg::side_t               side_o
);

  logic [tnac_pkg::SQ_W-1:0]   rad_r  [1:tnac_pkg::ROOT_W];
  logic [tnac_pkg::REM_W-1:0]  rem_r  [1:tnac_pkg::ROOT_W];
  logic [tnac_pkg::ROOT_W-1:0] root_r [1:tnac_pkg::ROOT_W];
  tnac_pkg::side_t             side_r [1:tnac_pkg::ROOT_W];
  logic                        v_r    [1:tnac_pkg::ROOT_W];

  // One root bit per stage: bring down two radicand bits, try 4*root+1.
  for (genvar k = 0; k < tnac_pkg::ROOT_W; k++) begin : g_step
    logic [tnac_pkg::SQ_W-1:0]   rad_c;
    logic [tnac_pkg::REM_W-1:0]  rem_c;
    logic [tnac_pkg::ROOT_W-1:0] root_c;
    tnac_pkg::side_t             side_c;
    logic                        v_c;
    logic [tnac_pkg::REM_W+1:0]  sh;
    logic [tnac_pkg::REM_W+1:0]  trial;
    logic                        ge;

    if (k == 0) begin : g_first
      assign rad_c  = rad_i;
      assign rem_c  = '0;
      assign root_c = '0;
      assign side_c = side_i;
      assign v_c    = v_i;
    end else begin : g_next
      assign rad_c  = rad_r[k];
      assign rem_c  = rem_r[k];
      assign root_c = root_r[k];
      assign side_c = side_r[k];
      assign v_c    = v_r[k];
    end

    assign sh    = {rem_c, rad_c[tnac_pkg::SQ_W-1 -: 2]};
    assign trial = (tnac_pkg::REM_W+2)'({root_c, 2'b01});
    assign ge    = (sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k+1]  <= rad_c << 2;
        rem_r[k+1]  <= ge ? tnac_pkg::REM_W'(sh - trial) : tnac_pkg::REM_W'(sh);
        root_r[k+1] <= {root_c[tnac_pkg::ROOT_W-2:0], ge};
        side_r[k+1] <= side_c;
      end
    end
  end

  assign v_o    = v_r[tnac_pkg::ROOT_W];
  assign root_o = root_r[tnac_pkg::ROOT_W];
  assign side_o = side_r[tnac_pkg::ROOT_W];

endmodule

[rtl/core/tnac_div.sv]
`timescale 1ns / 1ps

module tnac_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          v_i,
  input  logic [tnac_pkg::ROOT_W-1:0]   len_i,
  input  tnac_pkg::side_t               side_i,
  output logic                          v_o,
  output tnac_pkg::out_t                res_o
);

  logic [tnac_pkg::MAG_W-1:0] r_r [1:tnac_pkg::DIV_STAGES][3];
  logic [tnac_pkg::QUO_W-1:0] q_r [1:tnac_pkg::DIV_STAGES][3];
  tnac_pkg::dside_t           ds_r [1:tnac_pkg::DIV_STAGES];
  logic                       v_r [1:tnac_pkg::DIV_STAGES];
  tnac_pkg::out_t             res_r;
  logic                       vo_r;

  // First stage: integer quotient bit, which is one only when |x| equals the length.
  logic q0 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) q0[i] = (side_i.mag[i] >= len_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[1] <= 1'b0;
    end else if (en) begin
      v_r[1] <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q_r[1][i] <= tnac_pkg::QUO_W'(q0[i]);
        r_r[1][i] <= q0[i] ? side_i.mag[i] - len_i : side_i.mag[i];
      end
      ds_r[1].len <= len_i;
      ds_r[1].neg <= side_i.neg;
      ds_r[1].mid <= side_i.mid;
    end
  end

  // One fraction bit per stage on each of the three lanes.
  for (genvar j = 1; j < tnac_pkg::DIV_STAGES; j++) begin : g_step
    logic [tnac_pkg::MAG_W:0] sh [3];
    logic                     ge [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh[i] = {r_r[j][i], 1'b0};
        ge[i] = (sh[i] >= {1'b0, ds_r[j].len});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          r_r[j+1][i] <= ge[i] ? tnac_pkg::MAG_W'(sh[i] - {1'b0, ds_r[j].len})
                               : tnac_pkg::MAG_W'(sh[i]);
          q_r[j+1][i] <= {q_r[j][i][tnac_pkg::QUO_W-2:0], ge[i]};
        end
        ds_r[j+1] <= ds_r[j];
      end
    end
  end

  // Last stage: round half up on the magnitude, apply sign, form area and flag.
  logic                              rnd  [3];
  logic [tnac_pkg::QUO_W-1:0]        qf   [3];
  logic signed [tnac_pkg::NQ_W-1:0]  nv   [3];
  logic signed [tnac_pkg::NORM_W-1:0] nout [3];
  logic                              degen;
  logic [tnac_pkg::AREA_W-1:0]       lenp1;

  always_comb begin
    degen = (ds_r[tnac_pkg::DIV_STAGES].len == '0);
    lenp1 = tnac_pkg::AREA_W'(ds_r[tnac_pkg::DIV_STAGES].len) + tnac_pkg::AREA_W'(1);
    for (int i = 0; i < 3; i++) begin
      rnd[i]  = ({r_r[tnac_pkg::DIV_STAGES][i], 1'b0} >=
                 {1'b0, ds_r[tnac_pkg::DIV_STAGES].len});
      qf[i]   = q_r[tnac_pkg::DIV_STAGES][i] + tnac_pkg::QUO_W'(rnd[i]);
      nv[i]   = ds_r[tnac_pkg::DIV_STAGES].neg[i] ? -$signed(tnac_pkg::NQ_W'(qf[i]))
                                                  :  $signed(tnac_pkg::NQ_W'(qf[i]));
      nout[i] = degen ? '0 : tnac_pkg::NORM_W'(nv[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[tnac_pkg::DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.unit_normal_x <= nout[0];
      res_r.unit_normal_y <= nout[1];
      res_r.unit_normal_z <= nout[2];
      res_r.tri_area      <= lenp1 >> 1;
      res_r.mid_x         <= ds_r[tnac_pkg::DIV_STAGES].mid[0];
      res_r.mid_y         <= ds_r[tnac_pkg::DIV_STAGES].mid[1];
      res_r.mid_z         <= ds_r[tnac_pkg::DIV_STAGES].mid[2];
      res_r.degenerate    <= degen;
    end
  end

  assign v_o   = vo_r;
  assign res_o = res_r;

endmodule

[rtl/core/triangle_normal_area_centroid.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Beat
// in_       input      in_valid / in_stall  in_data  (tnac_pkg::in_t, three vertices)
// out_      output     out_valid / out_stall out_data (tnac_pkg::out_t, normal, area, centroid)
//
// One triangle per clock enters and leaves while no stall holds the pipeline; a beat
// passes 57 register stages (6 front, 34 square-root at one root bit each, 16 divider,
// 1 output register) on its way to out_data.
// The root pipeline, one bit per stage, sets the depth.
// Reset is synchronous, active low, and clears only the valid bits.
// A stalled result sits in the output register while the pipeline moves one more
// beat into a skid register; in_stall rises only while that skid register is full.

module triangle_normal_area_centroid (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  tnac_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output tnac_pkg::out_t  out_data
);

  logic                          en;
  logic                          fv;
  logic [tnac_pkg::SQ_W-1:0]     fsq;
  tnac_pkg::side_t               fside;
  logic                          sv;
  logic [tnac_pkg::ROOT_W-1:0]   sroot;
  tnac_pkg::side_t               sside;
  logic                          dv;
  tnac_pkg::out_t                dres;

  logic                          out_valid_r;
  tnac_pkg::out_t                out_data_r;
  logic                          skid_valid_r;
  tnac_pkg::out_t                skid_data_r;
  logic                          take;

  // The whole pipeline advances unless the skid register holds a beat.
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign take     = out_valid_r && !out_stall;

  tnac_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (in_valid),
    .data_i (in_data),
    .v_o    (fv),
    .sq_o   (fsq),
    .side_o (fside)
  );

  tnac_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (fv),
    .rad_i  (fsq),
    .side_i (fside),
    .v_o    (sv),
    .root_o (sroot),
    .side_o (sside)
  );

  tnac_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (sv),
    .len_i  (sroot),
    .side_i (sside),
    .v_o    (dv),
    .res_o  (dres)
  );

  // Output register with a one-beat skid behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (dv) begin
      if (!out_valid_r || take) begin
        out_data_r  <= dres;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= dres;
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/tnac_checker.sv]
`timescale 1ns / 1ps

module tnac_checker (
  input logic            clk,
  input logic            rst_n,
  input tnac_pkg::out_t  out_data,
  input logic            out_valid,
  input logic            out_stall
);

  // A held result beat keeps its valid.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A held result beat keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // A degenerate triangle has a zero normal and zero area.
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.unit_normal_x == '0 && out_data.unit_normal_y == '0 &&
      out_data.unit_normal_z == '0 && out_data.tri_area == '0)
    else $error("degenerate beat with nonzero normal or area");

  // Any real triangle has a nonzero area.
  a_area: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.degenerate |-> out_data.tri_area != '0)
    else $error("nondegenerate beat with zero area");

  // Nothing comes out right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind triangle_normal_area_centroid tnac_checker u_tnac_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

[dv/tb_triangle_normal_area_centroid.sv]
`timescale 1ns / 1ps

module tb_triangle_normal_area_centroid;

  localparam int LATENCY     = 57;
  localparam int STALL_LIMIT = 20000;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  tnac_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  tnac_pkg::out_t out_data;

  tnac_pkg::out_t expected_results[$];
  int   error_count;
  int   beats_sent;
  int   beats_checked;
  int   degenerate_seen;
  int   idle_cycles;
  bit   idle_enable;
  bit   timed_out;

  triangle_normal_area_centroid i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Integer square root of a value up to 68 bits, one result bit at a time.
  function automatic logic [35:0] isqrt68(logic [67:0] sq);
    logic [35:0] root;
    logic [35:0] cand;
    logic [71:0] cand_sq;
    root = '0;
    for (int b = 35; b >= 0; b--) begin
      cand = root | (36'd1 << b);
      cand_sq = 72'(cand) * 72'(cand);
      if (cand_sq <= 72'(sq)) root = cand;
    end
    return root;
  endfunction

  // Magnitude over length in Q1.14, rounded to nearest with halves up.
  function automatic logic [15:0] normal_mag(logic [35:0] num, logic [35:0] len);
    logic [51:0] scaled;
    logic [51:0] quo;
    logic [51:0] rem;
    scaled = 52'(num) << tnac_pkg::NORM_FRAC;
    quo = scaled / 52'(len);
    rem = scaled % 52'(len);
    if ((rem << 1) >= 52'(len)) quo = quo + 1;
    return quo[15:0];
  endfunction

  // Centroid axis: sum over three, magnitude rounded, sign reapplied.
  function automatic logic [15:0] centroid_axis(logic signed [15:0] a,
                                                logic signed [15:0] b,
                                                logic signed [15:0] c);
    longint s;
    longint q;
    s = longint'(a) + longint'(b) + longint'(c);
    q = ((s < 0 ? -s : s) + 1) / 3;
    return (s < 0) ? 16'(-q) : 16'(q);
  endfunction

  // Expected normal, area and centroid of one triangle.
  function automatic tnac_pkg::out_t triangle_geometry(tnac_pkg::in_t t);
    tnac_pkg::out_t r;
    longint e1 [3];
    longint e2 [3];
    longint xp [3];
    logic [35:0] xmag [3];
    logic [67:0] sq;
    logic [35:0] len;
    logic [15:0] m;
    e1[0] = longint'(t.vertex_b_x) - longint'(t.vertex_a_x);
    e1[1] = longint'(t.vertex_b_y) - longint'(t.vertex_a_y);
    e1[2] = longint'(t.vertex_b_z) - longint'(t.vertex_a_z);
    e2[0] = longint'(t.vertex_c_x) - longint'(t.vertex_a_x);
    e2[1] = longint'(t.vertex_c_y) - longint'(t.vertex_a_y);
    e2[2] = longint'(t.vertex_c_z) - longint'(t.vertex_a_z);
    xp[0] = e1[1] * e2[2] - e1[2] * e2[1];
    xp[1] = e1[2] * e2[0] - e1[0] * e2[2];
    xp[2] = e1[0] * e2[1] - e1[1] * e2[0];
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      xmag[i] = 36'(xp[i] < 0 ? -xp[i] : xp[i]);
      sq = sq + 68'(xmag[i]) * 68'(xmag[i]);
    end
    len = isqrt68(sq);
    r = '0;
    for (int i = 0; i < 3; i++) begin
      m = (len != 0) ? normal_mag(xmag[i], len) : 16'd0;
      if (xp[i] < 0) m = -m;
      if (i == 0) r.unit_normal_x = m;
      else if (i == 1) r.unit_normal_y = m;
      else r.unit_normal_z = m;
    end
    r.tri_area   = tnac_pkg::AREA_W'((37'(len) + 1) >> 1);
    r.mid_x      = centroid_axis(t.vertex_a_x, t.vertex_b_x, t.vertex_c_x);
    r.mid_y      = centroid_axis(t.vertex_a_y, t.vertex_b_y, t.vertex_c_y);
    r.mid_z      = centroid_axis(t.vertex_a_z, t.vertex_b_z, t.vertex_c_z);
    r.degenerate = (len == 0);
    return r;
  endfunction

  function automatic bit idle_now();
    return idle_enable && ($urandom_range(99) < 23);
  endfunction

  // Send one triangle, with an optional random gap in front of it.
  task automatic send_triangle(tnac_pkg::in_t t);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.insert(expected_results.size(), triangle_geometry(t));
    beats_sent++;
  endtask

  function automatic tnac_pkg::in_t make_triangle(
      logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
      logic [15:0] bx, logic [15:0] by, logic [15:0] bz,
      logic [15:0] cx, logic [15:0] cy, logic [15:0] cz);
    return '{ax, ay, az, bx, by, bz, cx, cy, cz};
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(4))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(64)) - 32);
      2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(4096)) - 2048);
    endcase
  endfunction

  // Extremes of the coordinates, degenerate and tiny triangles.
  task automatic test_directed();
    send_triangle(make_triangle(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                                16'd0, 16'd0, 16'd0));
    send_triangle(make_triangle(16'd0, 16'd0, 16'd0, 16'h0100, 16'd0, 16'd0,
                                16'd0, 16'h0100, 16'd0));
    send_triangle(make_triangle(16'd0, 16'd0, 16'd0, 16'd0, 16'h0100, 16'd0,
                                16'h0100, 16'd0, 16'd0));
    send_triangle(make_triangle(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0100,
                                16'h0100, 16'd0, 16'd0));
    send_triangle(make_triangle(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0,
                                16'd0, 16'd1, 16'd0));
    send_triangle(make_triangle(16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1,
                                16'd2, 16'd2, 16'd2));
    send_triangle(make_triangle(16'd5, 16'd6, 16'd7, 16'd5, 16'd6, 16'd7,
                                16'd9, 16'd9, 16'd9));
    send_triangle(make_triangle(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
                                16'h8000, 16'h7FFF, 16'h8000));
    send_triangle(make_triangle(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
                                16'h7FFF, 16'h8000, 16'h7FFF));
    send_triangle(make_triangle(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                                16'h8000, 16'h7FFF, 16'h7FFF));
    send_triangle(make_triangle(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                                16'h7FFF, 16'h7FFF, 16'h8000));
    send_triangle(make_triangle(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                16'h8000, 16'h8000, 16'h8000));
    send_triangle(make_triangle(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_triangle(make_triangle(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'd0,
                                16'd0, 16'd1, 16'd0));
    send_triangle(make_triangle(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                                16'd0, 16'd0, 16'd0));
    send_triangle(make_triangle(16'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                                16'd0, 16'd0, 16'd0));
    send_triangle(make_triangle(16'hFFFE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                                16'd0, 16'd0, 16'd0));
    send_triangle(make_triangle(16'd3, 16'd3, 16'd0, 16'hFFFD, 16'd7, 16'd0,
                                16'd0, 16'hFFF0, 16'h0001));
  endtask

  // Random triangles: mostly well-formed, some degenerate, and back-to-back stretches.
  task automatic test_random(int count);
    tnac_pkg::in_t t;
    for (int n = 0; n < count; n++) begin
      idle_enable = !(n >= count / 3 && n < count / 3 + 150);
      t = make_triangle(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord(), rand_coord());
      if ($urandom_range(19) == 0) begin
        // Collinear: C repeats B.
        t.vertex_c_x = t.vertex_b_x;
        t.vertex_c_y = t.vertex_b_y;
        t.vertex_c_z = t.vertex_b_z;
      end
      send_triangle(t);
    end
    idle_enable = 1'b1;
  endtask

  // Result side: random stalls and a field-by-field check of each beat.
  always @(posedge clk) begin
    tnac_pkg::out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no triangle outstanding");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          beats_checked++;
          if (out_data.degenerate) degenerate_seen++;
          if (out_data.unit_normal_x !== want.unit_normal_x) begin
            $error("unit_normal_x expected %0d actual %0d", want.unit_normal_x,
                   out_data.unit_normal_x);
            error_count++;
          end
          if (out_data.unit_normal_y !== want.unit_normal_y) begin
            $error("unit_normal_y expected %0d actual %0d", want.unit_normal_y,
                   out_data.unit_normal_y);
            error_count++;
          end
          if (out_data.unit_normal_z !== want.unit_normal_z) begin
            $error("unit_normal_z expected %0d actual %0d", want.unit_normal_z,
                   out_data.unit_normal_z);
            error_count++;
          end
          if (out_data.tri_area !== want.tri_area) begin
            $error("tri_area expected %0d actual %0d", want.tri_area, out_data.tri_area);
            error_count++;
          end
          if (out_data.mid_x !== want.mid_x) begin
            $error("mid_x expected %0d actual %0d", want.mid_x, out_data.mid_x);
            error_count++;
          end
          if (out_data.mid_y !== want.mid_y) begin
            $error("mid_y expected %0d actual %0d", want.mid_y, out_data.mid_y);
            error_count++;
          end
          if (out_data.mid_z !== want.mid_z) begin
            $error("mid_z expected %0d actual %0d", want.mid_z, out_data.mid_z);
            error_count++;
          end
          if (out_data.degenerate !== want.degenerate) begin
            $error("degenerate expected %0d actual %0d", want.degenerate,
                   out_data.degenerate);
            error_count++;
          end
        end
      end
      out_stall <= idle_now();
    end
  end

  // Watchdog: count cycles with no beat on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) timed_out = 1'b1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_stall       = 1'b0;
    error_count     = 0;
    beats_sent      = 0;
    beats_checked   = 0;
    degenerate_seen = 0;
    idle_cycles     = 0;
    idle_enable     = 1'b1;
    timed_out       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fork
      begin
        test_directed();
        test_random(1000);
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
      end
      begin
        wait (timed_out);
      end
    join_any

    if (timed_out) begin
      $display("Run stopped by the watchdog after %0d triangles sent and %0d results checked.",
               beats_sent, beats_checked);
      $display("** triangle_normal_area_centroid: FAILED **");
      $finish;
    end else begin
      $display("Sent %0d triangles and checked %0d results, %0d of them degenerate.",
               beats_sent, beats_checked, degenerate_seen);
      if (error_count == 0) begin
        $display("** triangle_normal_area_centroid: PASSED **");
      end else begin
        $display("** triangle_normal_area_centroid: FAILED **");
      end
      $finish;
    end
  end

endmodule
